/* hw/rtl/r2y_pkg.sv */
// Shared types and constants for the RGB to YUV 4:2:0 converter.
// Used by every module of the block; depends on nothing else.
package r2y_pkg;

  // Configuration register widths and indexes.
  localparam int CfgW   = 12;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 1'b1;
  localparam logic [CfgW-1:0] ResetWidth  = 12'd640;
  localparam logic [CfgW-1:0] ResetHeight = 12'd480;
  localparam logic [CfgW-1:0] MinDim      = 12'd2;

  // Line geometry.
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int AddrW     = ColW - 1;
  localparam int RowW      = 11;
  localparam logic [CfgW-1:0] MaxWidthV  = CfgW'(MaxWidth);
  localparam logic [CfgW-1:0] MaxHeightV = CfgW'(MaxHeight);

  // Queue depths.
  localparam int OpDepth   = 4;
  localparam int OpPtrW    = $clog2(OpDepth);
  localparam int OpCntW    = $clog2(OpDepth + 1);
  localparam int OutDepth  = 8;
  localparam int OutPtrW   = $clog2(OutDepth);
  localparam int OutCntW   = $clog2(OutDepth + 1);

  // BT.601 coefficients, 15 fractional bits.
  localparam int LumaW = 24;
  localparam int ChrW  = 25;
  localparam logic [LumaW-1:0] CoefYR = 24'd9798;
  localparam logic [LumaW-1:0] CoefYG = 24'd19235;
  localparam logic [LumaW-1:0] CoefYB = 24'd3736;
  localparam logic signed [ChrW-1:0] CoefUR = -25'sd5538;
  localparam logic signed [ChrW-1:0] CoefUG = -25'sd10846;
  localparam logic signed [ChrW-1:0] CoefUB = 25'sd16351;
  localparam logic signed [ChrW-1:0] CoefVR = 25'sd16351;
  localparam logic signed [ChrW-1:0] CoefVG = -25'sd13697;
  localparam logic signed [ChrW-1:0] CoefVB = -25'sd2664;
  localparam int FracBits = 15;
  localparam logic signed [ChrW-1:0] ChromaOffset = 25'sd128;
  localparam logic signed [ChrW-1:0] ChromaMax    = 25'sd255;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } result_t;

  // What the back end does with a word.
  typedef enum logic [1:0] {
    OP_STORE_UPPER = 2'd0,
    OP_HOLD_LEFT   = 2'd1,
    OP_BLOCK       = 2'd2
  } op_kind_e;

  typedef struct packed {
    pixel_t           pix;
    op_kind_e         kind;
    logic [ColW-1:0]  col;
    logic             frame_end;
  } op_t;

endpackage

/* hw/rtl/r2y_line_store.sv */
// Upper-row line store: even and odd columns in two banks so that both
// pixels above a 2x2 block are read at once. Uses r2y_pkg.
module r2y_line_store (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic                 wr_bank_i,
  input  logic [r2y_pkg::AddrW-1:0] wr_addr_i,
  input  r2y_pkg::pixel_t      wr_data_i,
  input  logic                 rd_en_i,
  input  logic [r2y_pkg::AddrW-1:0] rd_addr_i,
  output r2y_pkg::pixel_t      rd_even_o,
  output r2y_pkg::pixel_t      rd_odd_o
);

  r2y_pkg::pixel_t even_mem [2**r2y_pkg::AddrW];
  r2y_pkg::pixel_t odd_mem  [2**r2y_pkg::AddrW];
  r2y_pkg::pixel_t rd_even_q;
  r2y_pkg::pixel_t rd_odd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !wr_bank_i) begin
      even_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_even_q <= even_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_bank_i) begin
      odd_mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_odd_q <= odd_mem[rd_addr_i];
    end
  end

  assign rd_even_o = rd_even_q;
  assign rd_odd_o  = rd_odd_q;

endmodule

/* hw/rtl/r2y_front.sv */
// Front end: frame geometry registers, raster counters, word classification
// and the short operation queue toward the back end. Uses r2y_pkg.
module r2y_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [r2y_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [r2y_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        push_i,
  output logic                        full_o,
  input  r2y_pkg::pixel_t             in_data_i,
  output logic                        op_valid_o,
  input  logic                        op_pop_i,
  output r2y_pkg::op_t                op_o
);

  logic [r2y_pkg::CfgW-1:0] width_q, height_q;
  logic [r2y_pkg::CfgW-1:0] w_even, h_even, eff_w, eff_h;
  logic [r2y_pkg::CfgW-1:0] col_inc, row_inc;
  logic [r2y_pkg::ColW-1:0] col_q, col_d;
  logic [r2y_pkg::RowW-1:0] row_q, row_d;
  logic                     row_end, last_row, accept;
  r2y_pkg::op_t             op_new;

  r2y_pkg::op_t               q_mem [r2y_pkg::OpDepth];
  logic [r2y_pkg::OpPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [r2y_pkg::OpCntW-1:0] cnt_q, cnt_d;
  logic                       do_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= r2y_pkg::ResetWidth;
      height_q <= r2y_pkg::ResetHeight;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        r2y_pkg::RegFrameWidth:  width_q  <= cfg_wdata_i;
        r2y_pkg::RegFrameHeight: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: low bit dropped, then limited to the legal range.
  always_comb begin
    w_even = {width_q[r2y_pkg::CfgW-1:1], 1'b0};
    h_even = {height_q[r2y_pkg::CfgW-1:1], 1'b0};
    priority if (w_even < r2y_pkg::MinDim) begin
      eff_w = r2y_pkg::MinDim;
    end else if (w_even > r2y_pkg::MaxWidthV) begin
      eff_w = r2y_pkg::MaxWidthV;
    end else begin
      eff_w = w_even;
    end
    priority if (h_even < r2y_pkg::MinDim) begin
      eff_h = r2y_pkg::MinDim;
    end else if (h_even > r2y_pkg::MaxHeightV) begin
      eff_h = r2y_pkg::MaxHeightV;
    end else begin
      eff_h = h_even;
    end
  end

  assign accept   = push_i && !full_o;
  assign col_inc  = r2y_pkg::CfgW'(col_q) + r2y_pkg::CfgW'(1);
  assign row_inc  = r2y_pkg::CfgW'(row_q) + r2y_pkg::CfgW'(1);
  assign row_end  = (col_inc >= eff_w);
  assign last_row = (row_inc >= eff_h);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = last_row ? '0 : row_inc[r2y_pkg::RowW-1:0];
      end else begin
        col_d = col_inc[r2y_pkg::ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Even rows fill the line store; odd rows pair up left and right pixels.
  always_comb begin
    op_new.pix       = in_data_i;
    op_new.col       = col_q;
    op_new.frame_end = row_end && last_row;
    priority if (!row_q[0]) begin
      op_new.kind = r2y_pkg::OP_STORE_UPPER;
    end else if (!col_q[0]) begin
      op_new.kind = r2y_pkg::OP_HOLD_LEFT;
    end else begin
      op_new.kind = r2y_pkg::OP_BLOCK;
    end
  end

  assign full_o     = (cnt_q == r2y_pkg::OpCntW'(r2y_pkg::OpDepth));
  assign op_valid_o = (cnt_q != '0);
  assign do_pop     = op_pop_i && op_valid_o;
  assign op_o       = q_mem[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (accept && !do_pop) begin
      cnt_d = cnt_q + r2y_pkg::OpCntW'(1);
    end else if (!accept && do_pop) begin
      cnt_d = cnt_q - r2y_pkg::OpCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        wr_ptr_q <= wr_ptr_q + r2y_pkg::OpPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + r2y_pkg::OpPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem[wr_ptr_q] <= op_new;
    end
  end

endmodule

/* hw/rtl/r2y_back.sv */
// Back end: line store access, 2x2 averaging, luma and chroma arithmetic
// in three stages, and the result queue. Uses r2y_pkg and r2y_line_store.
module r2y_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_valid_i,
  output logic               op_pop_o,
  input  r2y_pkg::op_t       op_i,
  output logic               empty_o,
  input  logic               pop_i,
  output r2y_pkg::result_t   out_data_o
);

  logic                        issue, st_wr, st_rd;
  logic [r2y_pkg::OutCntW-1:0] out_cnt_q, out_cnt_d, in_flight;
  r2y_pkg::pixel_t             left_q, up_l, up_r;

  // Stage 1: line store data arrives.
  logic            v1_q, blk1_q, fend1_q;
  r2y_pkg::pixel_t pix1_q, left1_q;
  logic [9:0]      sum_r, sum_g, sum_b;
  logic [r2y_pkg::LumaW-1:0] luma_sum;

  // Stage 2: means and luma.
  logic       v2_q, blk2_q, fend2_q;
  logic [7:0] luma2_q, mr_q, mg_q, mb_q;
  logic signed [r2y_pkg::ChrW-1:0] mr_s, mg_s, mb_s, u_sum, v_sum;

  // Stage 3: chroma sums.
  logic       v3_q, blk3_q, fend3_q;
  logic [7:0] luma3_q;
  logic signed [r2y_pkg::ChrW-1:0] u_sum_q, v_sum_q, u_off, v_off;
  logic [7:0] u_clip, v_clip;
  r2y_pkg::result_t res;

  r2y_pkg::result_t              out_mem [r2y_pkg::OutDepth];
  logic [r2y_pkg::OutPtrW-1:0]   out_wr_q, out_rd_q;
  logic                          out_pop;

  // A word is issued only if the result queue has room for it and for
  // everything already in the pipeline, so the stages never stall.
  assign in_flight = r2y_pkg::OutCntW'(v1_q) + r2y_pkg::OutCntW'(v2_q)
                   + r2y_pkg::OutCntW'(v3_q);
  assign issue     = op_valid_i
                   && ((out_cnt_q + in_flight) < r2y_pkg::OutCntW'(r2y_pkg::OutDepth));
  assign op_pop_o  = issue;
  assign st_wr     = issue && (op_i.kind == r2y_pkg::OP_STORE_UPPER);
  assign st_rd     = issue && (op_i.kind == r2y_pkg::OP_BLOCK);

  r2y_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (st_wr),
    .wr_bank_i (op_i.col[0]),
    .wr_addr_i (op_i.col[r2y_pkg::ColW-1:1]),
    .wr_data_i (op_i.pix),
    .rd_en_i   (st_rd),
    .rd_addr_i (op_i.col[r2y_pkg::ColW-1:1]),
    .rd_even_o (up_l),
    .rd_odd_o  (up_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
    end else begin
      if (issue && (op_i.kind == r2y_pkg::OP_HOLD_LEFT)) begin
        left_q <= op_i.pix;
      end
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pix1_q  <= op_i.pix;
    left1_q <= left_q;
    blk1_q  <= (op_i.kind == r2y_pkg::OP_BLOCK);
    fend1_q <= op_i.frame_end;
  end

  always_comb begin
    sum_r = 10'(pix1_q.red) + 10'(left1_q.red) + 10'(up_l.red) + 10'(up_r.red);
    sum_g = 10'(pix1_q.green) + 10'(left1_q.green) + 10'(up_l.green)
          + 10'(up_r.green);
    sum_b = 10'(pix1_q.blue) + 10'(left1_q.blue) + 10'(up_l.blue) + 10'(up_r.blue);
    luma_sum = r2y_pkg::CoefYR * r2y_pkg::LumaW'(pix1_q.red)
             + r2y_pkg::CoefYG * r2y_pkg::LumaW'(pix1_q.green)
             + r2y_pkg::CoefYB * r2y_pkg::LumaW'(pix1_q.blue);
  end

  // The luma coefficients add up to just over one, so the result never
  // exceeds 255 and needs no clamp.
  always_ff @(posedge clk_i) begin
    blk2_q  <= blk1_q;
    fend2_q <= fend1_q;
    luma2_q <= luma_sum[r2y_pkg::FracBits +: 8];
    mr_q    <= 8'((sum_r + 10'd2) >> 2);
    mg_q    <= 8'((sum_g + 10'd2) >> 2);
    mb_q    <= 8'((sum_b + 10'd2) >> 2);
  end

  always_comb begin
    mr_s  = $signed(r2y_pkg::ChrW'(mr_q));
    mg_s  = $signed(r2y_pkg::ChrW'(mg_q));
    mb_s  = $signed(r2y_pkg::ChrW'(mb_q));
    u_sum = r2y_pkg::CoefUR * mr_s + r2y_pkg::CoefUG * mg_s + r2y_pkg::CoefUB * mb_s;
    v_sum = r2y_pkg::CoefVR * mr_s + r2y_pkg::CoefVG * mg_s + r2y_pkg::CoefVB * mb_s;
  end

  always_ff @(posedge clk_i) begin
    blk3_q  <= blk2_q;
    fend3_q <= fend2_q;
    luma3_q <= luma2_q;
    u_sum_q <= u_sum;
    v_sum_q <= v_sum;
  end

  // Arithmetic shift floors negative sums, then offset and clamp.
  always_comb begin
    u_off = (u_sum_q >>> r2y_pkg::FracBits) + r2y_pkg::ChromaOffset;
    v_off = (v_sum_q >>> r2y_pkg::FracBits) + r2y_pkg::ChromaOffset;
    priority if (u_off < 0) begin
      u_clip = 8'd0;
    end else if (u_off > r2y_pkg::ChromaMax) begin
      u_clip = 8'd255;
    end else begin
      u_clip = u_off[7:0];
    end
    priority if (v_off < 0) begin
      v_clip = 8'd0;
    end else if (v_off > r2y_pkg::ChromaMax) begin
      v_clip = 8'd255;
    end else begin
      v_clip = v_off[7:0];
    end
    res.luma         = luma3_q;
    res.chroma_valid = blk3_q;
    res.chroma_u     = blk3_q ? u_clip : 8'd0;
    res.chroma_v     = blk3_q ? v_clip : 8'd0;
    res.frame_end    = fend3_q;
  end

  assign empty_o    = (out_cnt_q == '0);
  assign out_pop    = pop_i && !empty_o;
  assign out_data_o = out_mem[out_rd_q];

  always_comb begin
    out_cnt_d = out_cnt_q;
    if (v3_q && !out_pop) begin
      out_cnt_d = out_cnt_q + r2y_pkg::OutCntW'(1);
    end else if (!v3_q && out_pop) begin
      out_cnt_d = out_cnt_q - r2y_pkg::OutCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
      out_wr_q  <= '0;
      out_rd_q  <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      if (v3_q) begin
        out_wr_q <= out_wr_q + r2y_pkg::OutPtrW'(1);
      end
      if (out_pop) begin
        out_rd_q <= out_rd_q + r2y_pkg::OutPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      out_mem[out_wr_q] <= res;
    end
  end

endmodule

/* hw/rtl/rgb_to_yuv420_subsample.sv */
// Path: a pushed word goes through the operation queue, the back-end stages
// and the result queue. Throughput: one word per clock, held while the result queue is short of room.
// The line store takes one write or one read per cycle, split into even/odd banks.
// Reset: counters cleared, width 640 and height 480, queues empty, left pixel zero;
// the line store is not cleared and is ready at once.
// Top level of the RGB to YUV 4:2:0 converter; uses r2y_pkg, r2y_front, r2y_back.
module rgb_to_yuv420_subsample (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [r2y_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [r2y_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  r2y_pkg::pixel_t             in_data_i,
  output logic                        empty,
  input  logic                        pop,
  output r2y_pkg::result_t            out_data_o
);

  logic         op_valid, op_pop;
  r2y_pkg::op_t op;

  r2y_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .full_o      (full),
    .in_data_i   (in_data_i),
    .op_valid_o  (op_valid),
    .op_pop_i    (op_pop),
    .op_o        (op)
  );

  r2y_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .op_i       (op),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule
